FILE: hdl/dse_pkg.sv
// shared constants, types and result codes of the statistics engine
package dse_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = 16 + IDX_W;
    localparam int SQ_W    = 31 + IDX_W;
    localparam int NSQ_W   = 2 * CNT_W;
    localparam int D_W     = 2 * SUM_W;
    localparam int DIVN_W  = D_W + 16;
    localparam int DIVD_W  = NSQ_W;
    localparam int DIVC_W  = $clog2(DIVN_W + 1);

    typedef enum logic [3:0] {
        KIND_COUNT    = 4'd0,
        KIND_SUM      = 4'd1,
        KIND_MEAN     = 4'd2,
        KIND_MIN      = 4'd3,
        KIND_MAX      = 4'd4,
        KIND_RANGE    = 4'd5,
        KIND_MEDIAN   = 4'd6,
        KIND_VARIANCE = 4'd7,
        KIND_STDDEV   = 4'd8,
        KIND_MODE     = 4'd9
    } stat_kind_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               is_last;
    } dse_item_t;

    typedef struct packed {
        stat_kind_t         stat_kind;
        logic signed [63:0] stat_value;
        logic               overflowed;
        logic               is_final;
    } dse_result_t;

    // sample write from intake into the sort row
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic signed [15:0] data;
    } dse_wr_t;

    // one finished set handed to the back end
    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic                    ovf;
    } dse_job_t;

endpackage

FILE: hdl/descriptive_statistics_engine.sv
// Descriptive statistics engine: load signed 16-bit samples one per cycle while busy is
// low, the last flagged; after the last one the engine sorts the set with an odd-even
// transposition row, scans it once, runs two serial divisions and a bit-serial square
// root, then drives count, sum, mean, min, max, range, median, variance and stddev on
// consecutive cycles, followed by the modes in ascending order during a second scan
// when a value repeats. busy stays high from the last sample until the final result;
// results are strobed for one cycle by valid and cannot be held off, so the receiver
// must take every transfer.
module descriptive_statistics_engine
    import dse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  dse_item_t   item,
    output logic        valid,
    output dse_result_t result
);

    dse_wr_t  wr;
    dse_job_t push_job;
    dse_job_t pop_job;
    logic     push;
    logic     pop;
    logic     not_empty;
    logic     done;

    dse_intake u_intake (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .done  (done),
        .wr    (wr),
        .push  (push),
        .job   (push_job)
    );

    dse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .job_in    (push_job),
        .pop       (pop),
        .job_out   (pop_job),
        .not_empty (not_empty)
    );

    dse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .not_empty (not_empty),
        .job_in    (pop_job),
        .pop       (pop),
        .done      (done),
        .valid     (valid),
        .result    (result)
    );

endmodule

FILE: hdl/dse_intake.sv
// front end: takes samples, keeps running sums, hands a finished set to the queue
module dse_intake
    import dse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dse_item_t item,
    output logic      busy,
    input  logic      done,
    output dse_wr_t   wr,
    output logic      push,
    output dse_job_t  job
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    ovf_reg, ovf_next;
    logic                    busy_reg;
    logic                    accept;
    logic                    has_room;
    logic signed [31:0]      square;

    assign accept   = start && !busy_reg;
    assign has_room = count_reg < CNT_W'(MAX_SAMPLES);
    assign square   = item.sample * item.sample;
    assign busy     = busy_reg;

    // running totals for the set being loaded
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        ovf_next   = ovf_reg;
        if (has_room)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + {{(SUM_W-16){item.sample[15]}}, item.sample};
            sq_next    = sq_reg + SQ_W'($unsigned(square));
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // store write and hand-off
    assign wr.en   = accept && has_room;
    assign wr.addr = count_reg[IDX_W-1:0];
    assign wr.data = item.sample;
    assign push    = accept && item.is_last;
    assign job.n   = count_next;
    assign job.sum = sum_next;
    assign job.sq  = sq_next;
    assign job.ovf = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (item.is_last)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    sq_reg    <= '0;
                    ovf_reg   <= 1'b0;
                    busy_reg  <= 1'b1;
                end
                else
                begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                    sq_reg    <= sq_next;
                    ovf_reg   <= ovf_next;
                end
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/dse_queue.sv
// two-entry queue of finished sets between intake and back end
module dse_queue
    import dse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dse_job_t job_in,
    input  logic     pop,
    output dse_job_t job_out,
    output logic     not_empty
);

    dse_job_t   entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign job_out   = entries_reg[rd_ptr_reg];
    assign not_empty = fill_reg != 2'd0;

    // payload entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/dse_divider.sv
// restoring divider, one quotient bit per cycle
module dse_divider
    import dse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] numer,
    input  logic [DIVD_W-1:0] denom,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    logic [DIVN_W-1:0] q_reg;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] den_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic              active_reg;
    logic              done_reg;
    logic [DIVD_W:0]   shifted;
    logic [DIVD_W:0]   diff;
    logic              ge;

    // one trial subtraction
    always_comb
    begin
        shifted  = {rem_reg, q_reg[DIVN_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? diff[DIVD_W-1:0] : shifted[DIVD_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (active_reg)
        begin
            q_reg   <= {q_reg[DIVN_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg    <= '0;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + DIVC_W'(1);
                if (cnt_reg == DIVC_W'(DIVN_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/dse_sqrt.sv
// integer square root, one result bit per cycle
module dse_sqrt
    import dse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        active_reg;
    logic        done_reg;
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    // bring down two bits and try the next root bit
    always_comb
    begin
        rem_sh   = {rem_reg[31:0], x_reg[63:62]};
        trial    = {root_reg, 2'b01};
        ge       = rem_sh >= trial;
        rem_next = ge ? rem_sh - trial : rem_sh;
    end

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (active_reg)
        begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[30:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg    <= '0;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/dse_back.sv
// back end: sorts the set, scans it, computes and sends the statistics and modes
module dse_back
    import dse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dse_wr_t     wr,
    input  logic        not_empty,
    input  dse_job_t    job_in,
    output logic        pop,
    output logic        done,
    output logic        valid,
    output dse_result_t result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_SCAN,
        ST_MUL,
        ST_SUB,
        ST_WAIT_M,
        ST_WAIT_V,
        ST_WAIT_S,
        ST_EMIT,
        ST_MODES
    } state_t;

    state_t                  state_reg;
    dse_job_t                job_reg;
    logic signed [15:0]      cells_reg [MAX_SAMPLES];
    logic signed [15:0]      sorted     [MAX_SAMPLES];
    logic [IDX_W-1:0]        pass_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic signed [15:0]      min_reg, max_reg, mid_lo_reg, mid_hi_reg, prev_reg;
    logic [CNT_W-1:0]        run_reg, best_reg, best_cnt_reg, emitted_reg;
    logic [D_W-1:0]          p1_reg, p2_reg;
    logic [NSQ_W-1:0]        nn_reg;
    logic signed [63:0]      mean_reg, var_reg, std_reg;
    stat_kind_t              kind_reg;
    logic                    div_start_reg, sqrt_start_reg;
    logic [DIVN_W-1:0]       div_numer_reg;
    logic [DIVD_W-1:0]       div_denom_reg;
    logic [63:0]             sqrt_in_reg;
    logic                    valid_reg, done_reg;
    dse_result_t             result_reg;

    logic                    div_done, sqrt_done;
    logic [DIVN_W-1:0]       div_q;
    logic [31:0]             sqrt_root;

    logic signed [15:0]      cur;
    logic                    in_set, same, close_prev, close_last;
    logic [CNT_W-1:0]        run_new, b1, c1, b2, c2;
    logic                    em_prev, em_last, emit;
    logic signed [15:0]      em_val;
    logic                    rotate;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [2*SUM_W-1:0] sum_sq;
    logic signed [16:0]      diff17, mid_sum;
    logic signed [63:0]      stat_val;
    logic                    stats_final;

    dse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .numer    (div_numer_reg),
        .denom    (div_denom_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    dse_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_in_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign pop    = (state_reg == ST_IDLE) && not_empty;
    assign rotate = (state_reg == ST_SCAN) || (state_reg == ST_MODES);
    assign done   = done_reg;
    assign valid  = valid_reg;
    assign result = result_reg;

    // one odd-even transposition pass over the stored part of the row
    always_comb
    begin
        for (int i = 0; i < MAX_SAMPLES; i++)
        begin
            sorted[i] = cells_reg[i];
        end
        for (int i = 0; i < MAX_SAMPLES - 1; i++)
        begin
            if ((1'(i) == pass_reg[0]) && (CNT_W'(i + 1) < job_reg.n)
                && (cells_reg[i] > cells_reg[i+1]))
            begin
                sorted[i]   = cells_reg[i+1];
                sorted[i+1] = cells_reg[i];
            end
        end
    end

    // sample row: intake writes, sort passes, rotation during scans
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cells_reg[wr.addr] <= wr.data;
        end
        else if (state_reg == ST_SORT)
        begin
            cells_reg <= sorted;
        end
        else if (rotate)
        begin
            for (int i = 0; i < MAX_SAMPLES - 1; i++)
            begin
                cells_reg[i] <= cells_reg[i+1];
            end
            cells_reg[MAX_SAMPLES-1] <= cells_reg[0];
        end
    end

    // run tracking over the sorted values at the head of the row
    always_comb
    begin
        cur        = cells_reg[0];
        in_set     = idx_reg < job_reg.n;
        same       = (idx_reg != '0) && (cur == prev_reg);
        close_prev = in_set && (idx_reg != '0) && !same;
        close_last = in_set && (idx_reg == job_reg.n - CNT_W'(1));
        run_new    = same ? run_reg + CNT_W'(1) : CNT_W'(1);

        b1 = best_reg;
        c1 = best_cnt_reg;
        if (close_prev)
        begin
            if (run_reg > best_reg)
            begin
                b1 = run_reg;
                c1 = CNT_W'(1);
            end
            else if (run_reg == best_reg)
            begin
                c1 = best_cnt_reg + CNT_W'(1);
            end
        end
        b2 = b1;
        c2 = c1;
        if (close_last)
        begin
            if (run_new > b1)
            begin
                b2 = run_new;
                c2 = CNT_W'(1);
            end
            else if (run_new == b1)
            begin
                c2 = c1 + CNT_W'(1);
            end
        end

        em_prev = close_prev && (run_reg == best_reg);
        em_last = close_last && (run_new == best_reg);
        emit    = em_prev || em_last;
        em_val  = em_prev ? prev_reg : cur;
    end

    // operand forms and statistic values
    always_comb
    begin
        sum_neg     = job_reg.sum[SUM_W-1];
        sum_mag     = sum_neg ? $unsigned(-job_reg.sum) : $unsigned(job_reg.sum);
        sum_sq      = job_reg.sum * job_reg.sum;
        diff17      = {max_reg[15], max_reg} - {min_reg[15], min_reg};
        mid_sum     = {mid_lo_reg[15], mid_lo_reg} + {mid_hi_reg[15], mid_hi_reg};
        stats_final = best_reg <= CNT_W'(1);
        unique case (kind_reg)
            KIND_COUNT:    stat_val = 64'(job_reg.n);
            KIND_SUM:      stat_val = {{(48-SUM_W){job_reg.sum[SUM_W-1]}}, job_reg.sum,
                                       16'b0};
            KIND_MEAN:     stat_val = mean_reg;
            KIND_MIN:      stat_val = {{32{min_reg[15]}}, min_reg, 16'b0};
            KIND_MAX:      stat_val = {{32{max_reg[15]}}, max_reg, 16'b0};
            KIND_RANGE:    stat_val = {{31{diff17[16]}}, diff17, 16'b0};
            KIND_MEDIAN:   stat_val = job_reg.n[0] ? {{32{mid_hi_reg[15]}}, mid_hi_reg, 16'b0}
                                                   : {{32{mid_sum[16]}}, mid_sum, 15'b0};
            KIND_VARIANCE: stat_val = var_reg;
            KIND_STDDEV:   stat_val = std_reg;
            default:       stat_val = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= '0;
            idx_reg        <= '0;
            run_reg        <= '0;
            best_reg       <= '0;
            best_cnt_reg   <= '0;
            emitted_reg    <= '0;
            kind_reg       <= KIND_COUNT;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            valid_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            valid_reg      <= 1'b0;
            done_reg       <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (not_empty)
                    begin
                        job_reg   <= job_in;
                        pass_reg  <= '0;
                        state_reg <= ST_SORT;
                    end
                end
                ST_SORT:
                begin
                    pass_reg <= pass_reg + IDX_W'(1);
                    if (pass_reg == IDX_W'(MAX_SAMPLES - 1))
                    begin
                        idx_reg      <= '0;
                        run_reg      <= '0;
                        best_reg     <= '0;
                        best_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (in_set)
                    begin
                        prev_reg     <= cur;
                        run_reg      <= run_new;
                        best_reg     <= b2;
                        best_cnt_reg <= c2;
                        if (idx_reg == '0)
                        begin
                            min_reg <= cur;
                        end
                        if (close_last)
                        begin
                            max_reg <= cur;
                        end
                        if (idx_reg == (job_reg.n >> 1))
                        begin
                            mid_hi_reg <= cur;
                        end
                        if (idx_reg == (job_reg.n >> 1) - CNT_W'(1))
                        begin
                            mid_lo_reg <= cur;
                        end
                    end
                    if (idx_reg == CNT_W'(MAX_SAMPLES - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    p1_reg <= {{(D_W-CNT_W){1'b0}}, job_reg.n}
                              * {{(D_W-SQ_W){1'b0}}, job_reg.sq};
                    p2_reg <= D_W'($unsigned(sum_sq));
                    nn_reg <= {{CNT_W{1'b0}}, job_reg.n} * {{CNT_W{1'b0}}, job_reg.n};
                    div_numer_reg <= DIVN_W'({sum_mag, 16'b0});
                    div_denom_reg <= DIVD_W'(job_reg.n);
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_SUB;
                end
                ST_SUB:
                begin
                    state_reg <= ST_WAIT_M;
                end
                ST_WAIT_M:
                begin
                    if (div_done)
                    begin
                        mean_reg      <= sum_neg ? -$signed(64'(div_q)) : $signed(64'(div_q));
                        div_numer_reg <= {p1_reg - p2_reg, 16'b0};
                        div_denom_reg <= nn_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_WAIT_V;
                    end
                end
                ST_WAIT_V:
                begin
                    if (div_done)
                    begin
                        var_reg        <= $signed(64'(div_q));
                        sqrt_in_reg    <= 64'(div_q) << 16;
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_WAIT_S;
                    end
                end
                ST_WAIT_S:
                begin
                    if (sqrt_done)
                    begin
                        std_reg   <= $signed(64'(sqrt_root));
                        kind_reg  <= KIND_COUNT;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    valid_reg             <= 1'b1;
                    result_reg.stat_kind  <= kind_reg;
                    result_reg.stat_value <= stat_val;
                    result_reg.overflowed <= job_reg.ovf;
                    result_reg.is_final   <= (kind_reg == KIND_STDDEV) && stats_final;
                    kind_reg              <= stat_kind_t'(kind_reg + 4'd1);
                    if (kind_reg == KIND_STDDEV)
                    begin
                        if (stats_final)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg     <= '0;
                            run_reg     <= '0;
                            emitted_reg <= '0;
                            state_reg   <= ST_MODES;
                        end
                    end
                end
                ST_MODES:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (in_set)
                    begin
                        prev_reg <= cur;
                        run_reg  <= run_new;
                    end
                    if (emit)
                    begin
                        valid_reg             <= 1'b1;
                        result_reg.stat_kind  <= KIND_MODE;
                        result_reg.stat_value <= {{32{em_val[15]}}, em_val, 16'b0};
                        result_reg.overflowed <= job_reg.ovf;
                        result_reg.is_final   <= emitted_reg + CNT_W'(1) == best_cnt_reg;
                        emitted_reg           <= emitted_reg + CNT_W'(1);
                    end
                    if ((emit && (emitted_reg + CNT_W'(1) == best_cnt_reg))
                        || (idx_reg == CNT_W'(MAX_SAMPLES - 1)))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
